// ----- sv/stw_pkg.sv -----
// package for the sparse tile walker: field widths, register indexes and shared types
package stw_pkg;

    localparam int IMG_W  = 15;
    localparam int LVL_W  = 4;
    localparam int OFF_W  = 14;
    localparam int EXT_W  = 15;
    localparam int CIDX_W = 3;

    typedef enum logic [CIDX_W-1:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_IMAGE_DEPTH  = 3'd2,
        REG_TILE_WIDTH   = 3'd3,
        REG_TILE_HEIGHT  = 3'd4,
        REG_TILE_DEPTH   = 3'd5,
        REG_TAIL_LEVEL   = 3'd6,
        REG_UNUSED       = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [IMG_W-1:0] image_width;
        logic [IMG_W-1:0] image_height;
        logic [IMG_W-1:0] image_depth;
        logic [IMG_W-1:0] tile_width;
        logic [IMG_W-1:0] tile_height;
        logic [IMG_W-1:0] tile_depth;
        logic [LVL_W-1:0] tail_first_level;
    } cfg_t;

    typedef struct packed {
        logic             valid_res;
        logic [LVL_W-1:0] mip_level;
        logic [OFF_W-1:0] offset_x;
        logic [OFF_W-1:0] offset_y;
        logic [OFF_W-1:0] offset_z;
        logic [EXT_W-1:0] extent_x;
        logic [EXT_W-1:0] extent_y;
        logic [EXT_W-1:0] extent_z;
        logic             last;
    } tile_t;

endpackage

// ----- sv/stw_step.sv -----
// one walk step: tile of the current position and the position that follows it
module stw_step #(
    parameter int COORD_BITS = 14
) (
    input  logic                     restart,
    input  stw_pkg::cfg_t            cfg,
    input  logic [stw_pkg::LVL_W-1:0] cur_level,
    input  logic [COORD_BITS-1:0]    pos_x,
    input  logic [COORD_BITS-1:0]    pos_y,
    input  logic [COORD_BITS-1:0]    pos_z,
    input  logic                     walk_done,
    output stw_pkg::tile_t           tile,
    output logic [stw_pkg::LVL_W-1:0] level_next,
    output logic [COORD_BITS-1:0]    pos_x_next,
    output logic [COORD_BITS-1:0]    pos_y_next,
    output logic [COORD_BITS-1:0]    pos_z_next,
    output logic                     done_next
);
    import stw_pkg::*;

    localparam int SUM_W = ((COORD_BITS > IMG_W) ? COORD_BITS : IMG_W) + 1;

    logic [LVL_W-1:0]      start_level;
    logic                  start_done;
    logic                  stop;
    logic                  last_level;
    logic [IMG_W-1:0]      img   [3];
    logic [IMG_W-1:0]      tcfg  [3];
    logic [COORD_BITS-1:0] pos   [3];
    logic [IMG_W-1:0]      shr   [3];
    logic [IMG_W-1:0]      lsz   [3];
    logic [IMG_W-1:0]      tsz   [3];
    logic [SUM_W-1:0]      sum   [3];
    logic [SUM_W-1:0]      ext   [3];
    logic                  hit   [3];
    logic [COORD_BITS-1:0] adv   [3];

    assign img[0]  = cfg.image_width;
    assign img[1]  = cfg.image_height;
    assign img[2]  = cfg.image_depth;
    assign tcfg[0] = cfg.tile_width;
    assign tcfg[1] = cfg.tile_height;
    assign tcfg[2] = cfg.tile_depth;

    always_comb
    begin
        start_level = restart ? '0 : cur_level;
        start_done  = restart ? (cfg.tail_first_level == '0) : walk_done;
        pos[0]      = restart ? '0 : pos_x;
        pos[1]      = restart ? '0 : pos_y;
        pos[2]      = restart ? '0 : pos_z;
        stop        = start_done || (start_level >= cfg.tail_first_level);
        last_level  = ({1'b0, start_level} + {{LVL_W{1'b0}}, 1'b1})
                      >= {1'b0, cfg.tail_first_level};
    end

    // per axis: level extent with floor, edge test, clipped extent
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            shr[a] = img[a] >> start_level;
            lsz[a] = (shr[a] == '0) ? IMG_W'(1) : shr[a];
            tsz[a] = (tcfg[a] == '0) ? IMG_W'(1) : tcfg[a];
            sum[a] = SUM_W'(pos[a]) + SUM_W'(tsz[a]);
            hit[a] = sum[a] >= SUM_W'(lsz[a]);
            ext[a] = hit[a] ? (SUM_W'(lsz[a]) - SUM_W'(pos[a])) : SUM_W'(tsz[a]);
            adv[a] = sum[a][COORD_BITS-1:0];
        end
    end

    always_comb
    begin
        tile       = '0;
        level_next = start_level;
        pos_x_next = pos[0];
        pos_y_next = pos[1];
        pos_z_next = pos[2];
        done_next  = 1'b1;
        if (!stop)
        begin
            tile.valid_res = 1'b1;
            tile.mip_level = start_level;
            tile.offset_x  = OFF_W'(pos[0]);
            tile.offset_y  = OFF_W'(pos[1]);
            tile.offset_z  = OFF_W'(pos[2]);
            tile.extent_x  = ext[0][EXT_W-1:0];
            tile.extent_y  = ext[1][EXT_W-1:0];
            tile.extent_z  = ext[2][EXT_W-1:0];
            tile.last      = hit[0] && hit[1] && hit[2] && last_level;
            done_next      = 1'b0;
            if (!hit[0])
            begin
                pos_x_next = adv[0];
            end
            else
            begin
                pos_x_next = '0;
                if (!hit[1])
                begin
                    pos_y_next = adv[1];
                end
                else
                begin
                    pos_y_next = '0;
                    if (!hit[2])
                    begin
                        pos_z_next = adv[2];
                    end
                    else
                    begin
                        pos_z_next = '0;
                        if (last_level)
                        begin
                            done_next = 1'b1;
                        end
                        else
                        begin
                            level_next = start_level + LVL_W'(1);
                        end
                    end
                end
            end
        end
    end

endmodule

// ----- sv/sparse_tile_walker.sv -----
// top level of the sparse tile walker: config registers, walk state and result buffer
//
// channel   direction  handshake               payload
// req       in         req_valid / req_stall   restart
// res       out        res_valid / res_stall   valid_res, mip_level, offset_*, extent_*, last
// cfg       in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// one request per cycle while req_stall is low; the tile is computed combinationally from
// the walk state and registered in the result buffer when the request is accepted
// reset clears walk state (walk finished) and loads register defaults
// a two-entry result buffer lets one more request in while a result is stalled
module sparse_tile_walker #(
    parameter int COORD_BITS = 14
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_stall,
    input  logic                       restart,
    output logic                       res_valid,
    input  logic                       res_stall,
    output logic                       valid_res,
    output logic [stw_pkg::LVL_W-1:0]  mip_level,
    output logic [stw_pkg::OFF_W-1:0]  offset_x,
    output logic [stw_pkg::OFF_W-1:0]  offset_y,
    output logic [stw_pkg::OFF_W-1:0]  offset_z,
    output logic [stw_pkg::EXT_W-1:0]  extent_x,
    output logic [stw_pkg::EXT_W-1:0]  extent_y,
    output logic [stw_pkg::EXT_W-1:0]  extent_z,
    output logic                       last,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [stw_pkg::CIDX_W-1:0] cfg_index,
    input  logic [stw_pkg::IMG_W-1:0]  cfg_data
);
    import stw_pkg::*;

    cfg_t                  cfg_reg;
    logic [LVL_W-1:0]      level_reg;
    logic [COORD_BITS-1:0] pos_x_reg;
    logic [COORD_BITS-1:0] pos_y_reg;
    logic [COORD_BITS-1:0] pos_z_reg;
    logic                  done_reg;

    logic [LVL_W-1:0]      level_next;
    logic [COORD_BITS-1:0] pos_x_next;
    logic [COORD_BITS-1:0] pos_y_next;
    logic [COORD_BITS-1:0] pos_z_next;
    logic                  done_next;
    tile_t                 tile;

    tile_t                 out_tile_reg;
    tile_t                 skid_tile_reg;
    logic                  out_full_reg;
    logic                  skid_full_reg;

    logic                  req_take;
    logic                  res_take;

    assign cfg_ready = 1'b1;
    assign req_stall = skid_full_reg;
    assign req_take  = req_valid && !skid_full_reg;
    assign res_valid = out_full_reg;
    assign res_take  = out_full_reg && !res_stall;

    assign valid_res = out_tile_reg.valid_res;
    assign mip_level = out_tile_reg.mip_level;
    assign offset_x  = out_tile_reg.offset_x;
    assign offset_y  = out_tile_reg.offset_y;
    assign offset_z  = out_tile_reg.offset_z;
    assign extent_x  = out_tile_reg.extent_x;
    assign extent_y  = out_tile_reg.extent_y;
    assign extent_z  = out_tile_reg.extent_z;
    assign last      = out_tile_reg.last;

    stw_step #(
        .COORD_BITS(COORD_BITS)
    ) u_step (
        .restart    (restart),
        .cfg        (cfg_reg),
        .cur_level  (level_reg),
        .pos_x      (pos_x_reg),
        .pos_y      (pos_y_reg),
        .pos_z      (pos_z_reg),
        .walk_done  (done_reg),
        .tile       (tile),
        .level_next (level_next),
        .pos_x_next (pos_x_next),
        .pos_y_next (pos_y_next),
        .pos_z_next (pos_z_next),
        .done_next  (done_next)
    );

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width      <= IMG_W'(1);
            cfg_reg.image_height     <= IMG_W'(1);
            cfg_reg.image_depth      <= IMG_W'(1);
            cfg_reg.tile_width       <= IMG_W'(1);
            cfg_reg.tile_height      <= IMG_W'(1);
            cfg_reg.tile_depth       <= IMG_W'(1);
            cfg_reg.tail_first_level <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_IMAGE_WIDTH:  cfg_reg.image_width      <= cfg_data;
                REG_IMAGE_HEIGHT: cfg_reg.image_height     <= cfg_data;
                REG_IMAGE_DEPTH:  cfg_reg.image_depth      <= cfg_data;
                REG_TILE_WIDTH:   cfg_reg.tile_width       <= cfg_data;
                REG_TILE_HEIGHT:  cfg_reg.tile_height      <= cfg_data;
                REG_TILE_DEPTH:   cfg_reg.tile_depth       <= cfg_data;
                REG_TAIL_LEVEL:   cfg_reg.tail_first_level <= cfg_data[LVL_W-1:0];
                default:          ;
            endcase
        end
    end

    // walk state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            pos_z_reg <= '0;
            done_reg  <= 1'b1;
        end
        else if (req_take)
        begin
            level_reg <= level_next;
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            pos_z_reg <= pos_z_next;
            done_reg  <= done_next;
        end
    end

    // result buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_full_reg  <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            if (!out_full_reg || res_take)
            begin
                out_full_reg  <= skid_full_reg || req_take;
                skid_full_reg <= 1'b0;
            end
            else if (req_take)
            begin
                skid_full_reg <= 1'b1;
            end
        end
    end

    // result buffer payload
    always_ff @(posedge clk)
    begin
        if (!out_full_reg || res_take)
        begin
            out_tile_reg <= skid_full_reg ? skid_tile_reg : tile;
        end
        if (out_full_reg && !res_take && req_take)
        begin
            skid_tile_reg <= tile;
        end
    end

endmodule

// ----- verif/testbench.sv -----
// self-checking testbench for sparse_tile_walker: directed table plus random walks
module testbench;
    import stw_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TARGET_ITEMS   = 450;

    typedef enum logic {
        ROW_CFG,
        ROW_REQ
    } row_kind_t;

    typedef struct {
        row_kind_t        kind;
        reg_idx_t         idx;
        logic [IMG_W-1:0] data;
        logic             rs;
        logic             pinned;
        tile_t            want;
    } plan_row_t;

    logic              clk;
    logic              rst_n;
    logic              req_valid;
    logic              req_stall;
    logic              restart;
    logic              res_valid;
    logic              res_stall;
    logic              valid_res;
    logic [LVL_W-1:0]  mip_level;
    logic [OFF_W-1:0]  offset_x;
    logic [OFF_W-1:0]  offset_y;
    logic [OFF_W-1:0]  offset_z;
    logic [EXT_W-1:0]  extent_x;
    logic [EXT_W-1:0]  extent_y;
    logic [EXT_W-1:0]  extent_z;
    logic              last;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CIDX_W-1:0] cfg_index;
    logic [IMG_W-1:0]  cfg_data;

    // shadow of the block: registers and walk position
    cfg_t             shadow_regs;
    logic [LVL_W-1:0] walk_lvl;
    logic [OFF_W-1:0] walk_x;
    logic [OFF_W-1:0] walk_y;
    logic [OFF_W-1:0] walk_z;
    logic             walk_over;

    tile_t       pending_tiles[$];
    plan_row_t   plan[$];
    int unsigned items_sent;
    int unsigned tiles_seen;
    int unsigned mismatches;
    int unsigned idle_cycles;
    int unsigned stall_hold;

    sparse_tile_walker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .restart   (restart),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .valid_res (valid_res),
        .mip_level (mip_level),
        .offset_x  (offset_x),
        .offset_y  (offset_y),
        .offset_z  (offset_z),
        .extent_x  (extent_x),
        .extent_y  (extent_y),
        .extent_z  (extent_z),
        .last      (last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int unsigned level_span(input logic [IMG_W-1:0] full,
                                               input logic [LVL_W-1:0] lvl);
        int unsigned v;
        v = full >> lvl;
        return (v == 0) ? 1 : v;
    endfunction

    // one walker step: updates the shadow position and returns the tile
    function automatic tile_t step_walker(input logic rs);
        int unsigned lw, lh, ld, tw, th, td;
        logic        lx, ly, lz, fin;
        tile_t       t;
        t = '0;
        if (rs)
        begin
            walk_lvl  = '0;
            walk_x    = '0;
            walk_y    = '0;
            walk_z    = '0;
            walk_over = (shadow_regs.tail_first_level == 0);
        end
        if (!walk_over && walk_lvl >= shadow_regs.tail_first_level)
            walk_over = 1'b1;
        if (walk_over)
            return t;
        lw = level_span(shadow_regs.image_width, walk_lvl);
        lh = level_span(shadow_regs.image_height, walk_lvl);
        ld = level_span(shadow_regs.image_depth, walk_lvl);
        tw = (shadow_regs.tile_width == 0) ? 1 : shadow_regs.tile_width;
        th = (shadow_regs.tile_height == 0) ? 1 : shadow_regs.tile_height;
        td = (shadow_regs.tile_depth == 0) ? 1 : shadow_regs.tile_depth;
        lx  = (walk_x + tw) >= lw;
        ly  = (walk_y + th) >= lh;
        lz  = (walk_z + td) >= ld;
        fin = (walk_lvl + 1) >= shadow_regs.tail_first_level;
        t.valid_res = 1'b1;
        t.mip_level = walk_lvl;
        t.offset_x  = walk_x;
        t.offset_y  = walk_y;
        t.offset_z  = walk_z;
        t.extent_x  = EXT_W'(lx ? lw - walk_x : tw);
        t.extent_y  = EXT_W'(ly ? lh - walk_y : th);
        t.extent_z  = EXT_W'(lz ? ld - walk_z : td);
        t.last      = lx && ly && lz && fin;
        if (!lx)
            walk_x = OFF_W'(walk_x + tw);
        else
        begin
            walk_x = '0;
            if (!ly)
                walk_y = OFF_W'(walk_y + th);
            else
            begin
                walk_y = '0;
                if (!lz)
                    walk_z = OFF_W'(walk_z + td);
                else
                begin
                    walk_z = '0;
                    if (fin)
                        walk_over = 1'b1;
                    else
                        walk_lvl = walk_lvl + 1'b1;
                end
            end
        end
        return t;
    endfunction

    function automatic tile_t mk_tile(input int unsigned lvl, input int unsigned ox,
                                      input int unsigned oy, input int unsigned oz,
                                      input int unsigned ex, input int unsigned ey,
                                      input int unsigned ez, input logic fin);
        tile_t t;
        t.valid_res = 1'b1;
        t.mip_level = LVL_W'(lvl);
        t.offset_x  = OFF_W'(ox);
        t.offset_y  = OFF_W'(oy);
        t.offset_z  = OFF_W'(oz);
        t.extent_x  = EXT_W'(ex);
        t.extent_y  = EXT_W'(ey);
        t.extent_z  = EXT_W'(ez);
        t.last      = fin;
        return t;
    endfunction

    function automatic void add_cfg(input reg_idx_t idx, input int unsigned data);
        plan_row_t r;
        r.kind   = ROW_CFG;
        r.idx    = idx;
        r.data   = IMG_W'(data);
        r.rs     = 1'b0;
        r.pinned = 1'b0;
        r.want   = '0;
        plan.insert(plan.size(), r);
    endfunction

    function automatic void add_step(input logic rs, input logic pinned, input tile_t want);
        plan_row_t r;
        r.kind   = ROW_REQ;
        r.idx    = REG_UNUSED;
        r.data   = '0;
        r.rs     = rs;
        r.pinned = pinned;
        r.want   = want;
        plan.insert(plan.size(), r);
    endfunction

    function automatic int unsigned edge_val();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 1;
            2:       return 16384;
            default: return 32767;
        endcase
    endfunction

    // wait until every request has produced its tile
    task automatic drain();
        if (req_valid)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        while (pending_tiles.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input int unsigned data);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= IMG_W'(data);
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_IMAGE_WIDTH:  shadow_regs.image_width      = IMG_W'(data);
            REG_IMAGE_HEIGHT: shadow_regs.image_height     = IMG_W'(data);
            REG_IMAGE_DEPTH:  shadow_regs.image_depth      = IMG_W'(data);
            REG_TILE_WIDTH:   shadow_regs.tile_width       = IMG_W'(data);
            REG_TILE_HEIGHT:  shadow_regs.tile_height      = IMG_W'(data);
            REG_TILE_DEPTH:   shadow_regs.tile_depth       = IMG_W'(data);
            REG_TAIL_LEVEL:   shadow_regs.tail_first_level = LVL_W'(data);
            default: ;
        endcase
    endtask

    task automatic issue_step(input logic rs, input logic pinned, input tile_t pin,
                              input bit no_gaps);
        int unsigned k;
        int unsigned gap;
        tile_t       predicted;
        if (cfg_valid)
            cfg_valid <= 1'b0;
        k = $urandom_range(0, 99);
        if (no_gaps || k < 55)
            gap = 0;
        else if (k < 93)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 40);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        restart   <= rs;
        do
            @(posedge clk);
        while (req_stall);
        predicted = step_walker(rs);
        pending_tiles.insert(pending_tiles.size(), pinned ? pin : predicted);
        items_sent++;
    endtask

    task automatic random_setup(output int unsigned phase_kind);
        int unsigned w, h, d, tw, th, td, tl;
        phase_kind = $urandom_range(0, 9);
        if (phase_kind == 0)
        begin
            w  = edge_val();
            h  = edge_val();
            d  = edge_val();
            tw = edge_val();
            th = edge_val();
            td = edge_val();
            tl = $urandom_range(0, 15);
        end
        else if (phase_kind == 1)
        begin
            w  = $urandom_range(0, 32767);
            h  = $urandom_range(0, 32767);
            d  = $urandom_range(0, 32767);
            tw = $urandom_range(0, 32767);
            th = $urandom_range(0, 32767);
            td = $urandom_range(0, 32767);
            tl = $urandom_range(0, 32767);
        end
        else
        begin
            w  = $urandom_range(1, 12);
            h  = $urandom_range(1, 12);
            d  = $urandom_range(1, 4);
            tw = $urandom_range(0, 6);
            th = $urandom_range(0, 6);
            td = $urandom_range(0, 3);
            tl = ($urandom_range(0, 4) == 0) ? 14 : $urandom_range(1, 5);
        end
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_IMAGE_DEPTH, d);
        write_reg(REG_TILE_WIDTH, tw);
        write_reg(REG_TILE_HEIGHT, th);
        write_reg(REG_TILE_DEPTH, td);
        write_reg(REG_TAIL_LEVEL, tl);
        if ($urandom_range(0, 7) == 0)
            write_reg(REG_UNUSED, $urandom_range(0, 32767));
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            if (mismatches < 10)
                $display("tile %0d %s: expected %0h, got %0h", tiles_seen, name, want, got);
            mismatches++;
        end
    endtask

    // result side: random stall and compare against the oldest expected tile
    always @(posedge clk)
    begin
        int unsigned k;
        tile_t       want;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (pending_tiles.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("tile %0d: result with no request outstanding", tiles_seen);
                    mismatches++;
                end
                else
                begin
                    want = pending_tiles.pop_front();
                    check_field("valid_res", want.valid_res, valid_res);
                    check_field("mip_level", want.mip_level, mip_level);
                    check_field("offset_x", want.offset_x, offset_x);
                    check_field("offset_y", want.offset_y, offset_y);
                    check_field("offset_z", want.offset_z, offset_z);
                    check_field("extent_x", want.extent_x, extent_x);
                    check_field("extent_y", want.extent_y, extent_y);
                    check_field("extent_z", want.extent_z, extent_z);
                    check_field("last", want.last, last);
                end
                tiles_seen++;
            end
            if (stall_hold != 0)
                stall_hold--;
            else
            begin
                k = $urandom_range(0, 99);
                if (k < 30)
                begin
                    res_stall  <= 1'b1;
                    stall_hold = $urandom_range(0, 2);
                end
                else if (k < 34)
                begin
                    res_stall  <= 1'b1;
                    stall_hold = $urandom_range(15, 50);
                end
                else
                begin
                    res_stall  <= 1'b0;
                    stall_hold = (k < 90) ? $urandom_range(0, 4) : $urandom_range(20, 60);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (res_valid && !res_stall)
                || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned phase_kind;
        int unsigned n;
        bit          noise;
        bit          burst;
        logic        rs;
        clk         = 1'b0;
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        restart     = 1'b0;
        res_stall   = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        items_sent  = 0;
        tiles_seen  = 0;
        mismatches  = 0;
        idle_cycles = 0;
        stall_hold  = 0;
        shadow_regs.image_width      = 1;
        shadow_regs.image_height     = 1;
        shadow_regs.image_depth      = 1;
        shadow_regs.tile_width       = 1;
        shadow_regs.tile_height      = 1;
        shadow_regs.tile_depth       = 1;
        shadow_regs.tail_first_level = 0;
        walk_lvl  = '0;
        walk_x    = '0;
        walk_y    = '0;
        walk_z    = '0;
        walk_over = 1'b1;

        // after reset nothing to walk, and a restart with no tiled level is empty
        add_step(1'b0, 1'b1, '0);
        add_step(1'b1, 1'b1, '0);
        // 5x4x1 image, 2x2x1 tiles, two tiled levels; clipped column at x=4
        add_cfg(REG_IMAGE_WIDTH, 5);
        add_cfg(REG_IMAGE_HEIGHT, 4);
        add_cfg(REG_IMAGE_DEPTH, 1);
        add_cfg(REG_TILE_WIDTH, 2);
        add_cfg(REG_TILE_HEIGHT, 2);
        add_cfg(REG_TILE_DEPTH, 1);
        add_cfg(REG_TAIL_LEVEL, 2);
        add_step(1'b1, 1'b1, mk_tile(0, 0, 0, 0, 2, 2, 1, 1'b0));
        add_step(1'b0, 1'b1, mk_tile(0, 2, 0, 0, 2, 2, 1, 1'b0));
        add_step(1'b0, 1'b1, mk_tile(0, 4, 0, 0, 1, 2, 1, 1'b0));
        add_step(1'b0, 1'b1, mk_tile(0, 0, 2, 0, 2, 2, 1, 1'b0));
        add_step(1'b0, 1'b1, mk_tile(0, 2, 2, 0, 2, 2, 1, 1'b0));
        add_step(1'b0, 1'b1, mk_tile(0, 4, 2, 0, 1, 2, 1, 1'b0));
        add_step(1'b0, 1'b1, mk_tile(1, 0, 0, 0, 2, 2, 1, 1'b1));
        add_step(1'b0, 1'b1, '0);
        add_step(1'b1, 1'b1, mk_tile(0, 0, 0, 0, 2, 2, 1, 1'b0));
        add_step(1'b0, 1'b1, mk_tile(0, 2, 0, 0, 2, 2, 1, 1'b0));
        // tail pulled down to the current level mid-walk
        add_cfg(REG_TAIL_LEVEL, 0);
        add_step(1'b0, 1'b1, '0);
        // image and tile sizes of 16384
        add_cfg(REG_IMAGE_WIDTH, 16384);
        add_cfg(REG_IMAGE_HEIGHT, 16384);
        add_cfg(REG_IMAGE_DEPTH, 16384);
        add_cfg(REG_TILE_WIDTH, 16384);
        add_cfg(REG_TILE_HEIGHT, 16384);
        add_cfg(REG_TILE_DEPTH, 16384);
        add_cfg(REG_TAIL_LEVEL, 3);
        add_step(1'b1, 1'b1, mk_tile(0, 0, 0, 0, 16384, 16384, 16384, 1'b0));
        add_step(1'b0, 1'b0, '0);
        add_step(1'b0, 1'b0, '0);
        add_step(1'b0, 1'b1, '0);
        // oversized and zero sizes, offset wrap, write to the spare index
        add_cfg(REG_IMAGE_WIDTH, 32767);
        add_cfg(REG_IMAGE_HEIGHT, 0);
        add_cfg(REG_IMAGE_DEPTH, 32767);
        add_cfg(REG_TILE_HEIGHT, 0);
        add_cfg(REG_TILE_DEPTH, 32767);
        add_cfg(REG_TAIL_LEVEL, 32767);
        add_cfg(REG_UNUSED, 'h2AAA);
        add_step(1'b1, 1'b0, '0);
        add_step(1'b0, 1'b0, '0);
        add_step(1'b0, 1'b0, '0);
        add_step(1'b0, 1'b0, '0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
                write_reg(plan[i].idx, plan[i].data);
            else
                issue_step(plan[i].rs, plan[i].pinned, plan[i].want, 1'b0);
        end

        while (items_sent < TARGET_ITEMS)
        begin
            random_setup(phase_kind);
            n     = (phase_kind <= 1) ? $urandom_range(5, 20) : $urandom_range(20, 70);
            noise = ($urandom_range(0, 9) == 0);
            burst = ($urandom_range(0, 4) == 0);
            for (int i = 0; i < n && items_sent < TARGET_ITEMS; i++)
            begin
                if (i == 0)
                    rs = ($urandom_range(0, 4) != 0);
                else if (noise)
                    rs = 1'($urandom_range(0, 1));
                else
                    rs = ($urandom_range(0, 39) == 0);
                if ($urandom_range(0, 49) == 0)
                    drain();
                issue_step(rs, 1'b0, '0, burst);
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/stw_pkg.sv
sv/stw_step.sv
sv/sparse_tile_walker.sv
verif/testbench.sv
